// ----- hdl/sine_tone_generator_top_macros.svh -----
// assertion macros for the sine tone generator
// expects signals named clock and reset in the module that includes this header
`ifndef SINE_TONE_GENERATOR_TOP_MACROS_SVH
`define SINE_TONE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define STG_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define STG_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/stg_pkg.sv -----
// shared constants, types and the quarter-wave table builder for the sine tone generator
// no dependencies
package stg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_CHANNELS    = 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int COUNT_W    = 4;
   localparam int CHAN_W     = 3;

   localparam int TABLE_DEPTH = 1 << TABLE_ADDR_BITS;
   localparam int MAG_W       = SAMPLE_BITS - 1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PHASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   // half-amplitude peak, 2^(SAMPLE_BITS-2)
   localparam logic [MAG_W-1:0] SINE_PEAK = MAG_W'(1 << (SAMPLE_BITS - 2));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'(1 << (SAMPLE_BITS - 2));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] Q29_HALF    = 64'd1 << 29;

   // (2k)(2k+1) denominators of the taylor series of sine
   localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

   typedef logic [MAG_W-1:0] qtab_type [TABLE_DEPTH];

   // quarter-wave magnitudes, evaluated once at elaboration in q30 fixed point
   function automatic qtab_type build_qtab();
      qtab_type    tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] v;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> 30;
         term = x;
         pos  = x;
         neg  = '0;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         s = (pos > neg) ? (pos - neg) : 64'd0;
         if (s > Q30_ONE) begin
            s = Q30_ONE;
         end
         v = (s * 64'(SINE_PEAK) + Q29_HALF) >> 30;
         if (v > 64'(SINE_PEAK)) begin
            v = 64'(SINE_PEAK);
         end
         tab[i] = MAG_W'(v);
      end
      return tab;
   endfunction

endpackage

// ----- hdl/stg_qrom.sv -----
// quarter-wave sine magnitude rom with registered read
// depends on stg_pkg for the table builder and widths
module stg_qrom (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [stg_pkg::TABLE_ADDR_BITS-1:0] rd_addr,
   output logic [stg_pkg::MAG_W-1:0]           rd_data
);
   import stg_pkg::*;

   localparam qtab_type QTAB = build_qtab();

   logic [MAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= QTAB[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sine_tone_generator_top.sv -----
// channel   | direction | handshake           | payload
// req       | in        | req_valid/req_stall | req_restart
// rsp       | out       | rsp_valid/rsp_stall | rsp_sample, rsp_channel, rsp_last
// csr       | in        | csr_wen             | csr_index, csr_wdata
//
// the first result of a frame passes the rom/sign stage, then the output stage register
// one result per cycle while rsp is not stalled; a frame gives channel_count results (1 to 8) on the rsp side
// a request is taken every cycle the rom/sign stage is free, also while rsp is stalled
// reset is synchronous and brings back phase 0, step 0, start 0 and two channels
// depends on stg_pkg, stg_qrom and sine_tone_generator_top_macros.svh
`include "sine_tone_generator_top_macros.svh"

module sine_tone_generator_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [stg_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic [stg_pkg::CHAN_W-1:0]             rsp_channel,
   output logic                                   rsp_last,
   input  logic                                   csr_wen,
   input  logic [stg_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import stg_pkg::*;

   // configuration and phase state
   logic [PHASE_BITS-1:0] phase_step_ff;
   logic [PHASE_BITS-1:0] start_phase_ff;
   logic [COUNT_W-1:0]    chan_count_ff;
   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;

   // rom/sign stage
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s1_neg_ff;
   logic                  s1_peak_ff;
   logic [COUNT_W-1:0]    s1_count_ff;
   logic [MAG_W-1:0]      rom_data;

   // output stage
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_in;
   logic [CHAN_W-1:0]             out_chan_ff;
   logic [CHAN_W-1:0]             out_chan_in;
   logic                          out_last_ff;
   logic                          out_last_in;
   logic [COUNT_W-1:0]            out_count_ff;
   logic [COUNT_W-1:0]            out_count_in;

   logic                       req_fire;
   logic                       out_take;
   logic                       out_free;
   logic                       s1_move;
   logic [PHASE_BITS-1:0]      phase_cur;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] taddr;
   logic [TABLE_ADDR_BITS-1:0] rom_addr;
   logic [COUNT_W-1:0]         count_eff;
   logic [MAG_W-1:0]           mag;
   logic [CHAN_W-1:0]          chan_next;

   assign out_take  = out_valid_ff & ~rsp_stall;
   assign out_free  = ~out_valid_ff | (out_take & out_last_ff);
   assign s1_move   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~s1_move;
   assign req_fire  = req_valid & ~req_stall;

   // phase of this frame and table address
   always_comb begin
      phase_cur = req_restart ? start_phase_ff : phase_acc_ff;
      quad      = phase_cur[PHASE_BITS-1 -: 2];
      taddr     = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      // falling quadrants read the mirrored entry; a zero offset there is the peak
      rom_addr  = quad[0] ? (TABLE_ADDR_BITS'(0) - taddr) : taddr;
      phase_acc_in = phase_cur + phase_step_ff;
      if (chan_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (chan_count_ff > COUNT_W'(MAX_CHANNELS)) begin
         count_eff = COUNT_W'(MAX_CHANNELS);
      end else begin
         count_eff = chan_count_ff;
      end
   end

   stg_qrom u_qrom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         start_phase_ff <= '0;
         chan_count_ff  <= COUNT_RESET;
         phase_acc_ff   <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_PHASE_STEP:    phase_step_ff  <= csr_wdata[PHASE_BITS-1:0];
               CSR_START_PHASE:   start_phase_ff <= csr_wdata[PHASE_BITS-1:0];
               CSR_CHANNEL_COUNT: chan_count_ff  <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            phase_acc_ff <= phase_acc_in;
         end
      end
   end

   // rom/sign stage
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_neg_ff   <= quad[1];
         s1_peak_ff  <= quad[0] & (taddr == '0);
         s1_count_ff <= count_eff;
      end
   end

   // output stage: one copy of the frame sample per channel
   always_comb begin
      mag       = s1_peak_ff ? SINE_PEAK : rom_data;
      chan_next = out_chan_ff + CHAN_W'(1);
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      out_chan_in   = out_chan_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;
      if (s1_move) begin
         out_valid_in  = 1'b1;
         out_sample_in = s1_neg_ff ? (SAMPLE_BITS'(0) - {1'b0, mag}) : {1'b0, mag};
         out_chan_in   = '0;
         out_last_in   = (s1_count_ff == COUNT_W'(1));
         out_count_in  = s1_count_ff;
      end else if (out_take) begin
         if (out_last_ff) begin
            out_valid_in = 1'b0;
         end else begin
            out_chan_in = chan_next;
            out_last_in = (COUNT_W'(chan_next) == (out_count_ff - COUNT_W'(1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_chan_ff   <= out_chan_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_sample  = out_sample_ff;
   assign rsp_channel = out_chan_ff;
   assign rsp_last    = out_last_ff;

   `STG_ASSERT_IMP(a_last_on_final_chan, out_valid_ff && out_last_ff, COUNT_W'(out_chan_ff) == (out_count_ff - COUNT_W'(1)), "last not on final channel")
   `STG_ASSERT_IMP(a_sample_range, rsp_valid, (rsp_sample >= SAMPLE_MIN) && (rsp_sample <= SAMPLE_MAX), "sample beyond half amplitude")
   `STG_ASSERT_NXT(a_chan_steps, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && (rsp_channel == $past(rsp_channel) + CHAN_W'(1)) && $stable(rsp_sample), "channel copy did not advance")
   `STG_ASSERT_NXT(a_frame_follows, rsp_valid && !rsp_stall && rsp_last && s1_valid_ff, rsp_valid && (rsp_channel == '0), "pending frame not started")

endmodule

// ----- verif/sine_tone_generator_top_tb.sv -----
// self-checking testbench for sine_tone_generator_top: frame requests in, per-channel samples out
// predicts each frame from its own quarter-wave sine and phase accumulator, checks in order
// depends on stg_pkg and the sine_tone_generator_top rtl
module sine_tone_generator_top_tb;
   import stg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 16;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_W-1:0]             channel;
      logic                          last;
   } chan_sample_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;
   logic [CHAN_W-1:0]             rsp_channel;
   logic                          rsp_last;
   logic                          csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   // predicted state of the oscillator
   logic [PHASE_BITS-1:0] tone_phase = '0;
   logic [PHASE_BITS-1:0] step_reg   = '0;
   logic [PHASE_BITS-1:0] start_reg  = '0;
   logic [COUNT_W-1:0]    count_reg  = COUNT_RESET;

   chan_sample_type expected_samples[$];

   int  error_count     = 0;
   int  frames_sent     = 0;
   int  samples_checked = 0;
   int  config_writes   = 0;
   bit  steady          = 1'b0;
   bit  hold_armed      = 1'b0;
   int  hold_done       = 0;

   sine_tone_generator_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_last),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout: %0d samples still pending", expected_samples.size());
      $display("*** FAILED ***");
      $finish;
   end

   // quarter-wave magnitude at table point idx, taylor series in q30
   function automatic longint unsigned quarter_mag(int unsigned idx);
      longint unsigned peak;
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned plus_sum;
      longint unsigned minus_sum;
      longint unsigned net;
      longint unsigned scaled;
      longint unsigned denom;
      peak = 64'd1 << (SAMPLE_BITS - 2);
      if (idx >= (1 << TABLE_ADDR_BITS)) return peak;
      ang       = (64'(idx) * PI_HALF_Q30) >> TABLE_ADDR_BITS;
      ang_sq    = (ang * ang) >> 30;
      term      = ang;
      plus_sum  = ang;
      minus_sum = 64'd0;
      for (int k = 1; k <= 6; k++) begin
         denom = 64'((2 * k) * (2 * k + 1));
         term  = ((term * ang_sq) >> 30) / denom;
         if (k % 2 == 1) minus_sum += term;
         else plus_sum += term;
      end
      net = (plus_sum > minus_sum) ? plus_sum - minus_sum : 64'd0;
      if (net > (64'd1 << 30)) net = 64'd1 << 30;
      scaled = (net * peak + (64'd1 << 29)) >> 30;
      if (scaled > peak) scaled = peak;
      return scaled;
   endfunction

   // top two phase bits pick the quadrant, the next ones the table point
   function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(
      input logic [PHASE_BITS-1:0] phase);
      logic [1:0]      quad;
      int unsigned     addr;
      longint unsigned mag;
      quad = phase[PHASE_BITS-1 -: 2];
      addr = 32'(phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]);
      mag  = quad[0] ? quarter_mag((1 << TABLE_ADDR_BITS) - addr) : quarter_mag(addr);
      return quad[1] ? -(SAMPLE_BITS'(mag)) : SAMPLE_BITS'(mag);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // compare every accepted sample with the oldest prediction
   always @(posedge clock) begin : check_samples
      chan_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d on channel %0d",
                                      rsp_sample, rsp_channel));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample !== want.sample)
               report_mismatch($sformatf("sample %0d, want %0d (channel %0d)",
                                         rsp_sample, want.sample, want.channel));
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel %0d, want %0d", rsp_channel, want.channel));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b on channel %0d",
                                         rsp_last, want.last, want.channel));
         end
      end
   end

   // receiver: random stalls, one long hold-off when armed, none while steady
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && hold_done < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_done <= hold_done + 1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CSR_PHASE_STEP:    step_reg  = data;
         CSR_START_PHASE:   start_reg = data;
         CSR_CHANNEL_COUNT: count_reg = data[COUNT_W-1:0];
         default: ;
      endcase
      config_writes++;
      @(posedge clock);
   endtask

   task automatic set_tone(input logic [31:0] step, input logic [31:0] start,
                           input logic [31:0] count_word);
      csr_write(CSR_PHASE_STEP, step);
      csr_write(CSR_START_PHASE, start);
      csr_write(CSR_CHANNEL_COUNT, count_word);
   endtask

   // send one frame request and predict its samples once it is taken
   task automatic send_frame(input logic restart);
      int                            gap;
      int                            n_chan;
      logic signed [SAMPLE_BITS-1:0] smp;
      chan_sample_type               item;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_restart <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (restart) tone_phase = start_reg;
      n_chan = (count_reg == 0) ? 1 : (count_reg > MAX_CHANNELS) ? MAX_CHANNELS : count_reg;
      smp = tone_sample(tone_phase);
      for (int c = 0; c < n_chan; c++) begin
         item.sample  = smp;
         item.channel = CHAN_W'(c);
         item.last    = (c == n_chan - 1);
         expected_samples.push_back(item);
      end
      tone_phase = tone_phase + step_reg;
      frames_sent++;
   endtask

   // wait for all predicted samples, then for the pipeline to go quiet
   task automatic drain_frames();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
         expected_samples.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // defaults after reset: step 0, start 0, two channels
   task automatic test_reset_state();
      send_frame(1'b0);
      send_frame(1'b1);
      send_frame(1'b0);
      drain_frames();
   endtask

   // quarter-turn steps land on zero crossings and both peaks
   task automatic test_quadrants();
      set_tone(32'h4000_0000, 32'h0000_0000, 32'h0000_0001);
      send_frame(1'b1);
      repeat (3) send_frame(1'b0);
      send_frame(1'b1);
      drain_frames();
   endtask

   // all-ones step and start, upper bits of the count word ignored
   task automatic test_phase_extremes();
      set_tone(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF3);
      send_frame(1'b1);
      send_frame(1'b0);
      drain_frames();
   endtask

   // zero channels acts as one, above eight saturates at eight
   task automatic test_channel_limits();
      logic [31:0] words[5] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0008,
                                32'hFFFF_FFF9, 32'hFFFF_FFFF};
      foreach (words[i]) begin
         csr_write(CSR_CHANNEL_COUNT, words[i]);
         send_frame(1'b0);
         drain_frames();
      end
   endtask

   // writes to the unused register index change nothing
   task automatic test_unused_index();
      csr_write(CSR_UNUSED, 32'h0000_0001);
      send_frame(1'b1);
      drain_frames();
   endtask

   task automatic test_random_tones(input int phases, input int frames);
      logic [31:0] count_word;
      for (int p = 0; p < phases; p++) begin
         count_word = $urandom();
         if ($urandom_range(0, 3) != 0) count_word[3:0] = 4'($urandom_range(1, 8));
         set_tone($urandom(), $urandom(), count_word);
         steady = (p == 2);
         send_frame(1'($urandom_range(0, 1)));
         for (int i = 1; i < frames; i++) send_frame($urandom_range(0, 7) == 0);
         drain_frames();
         steady = 1'b0;
      end
   endtask

   // hold the output long enough that requests back up into the input
   task automatic test_backpressure();
      set_tone($urandom(), $urandom(), 32'h0000_0008);
      steady     = 1'b1;
      hold_armed = 1'b1;
      for (int i = 0; i < 40; i++) send_frame($urandom_range(0, 7) == 0);
      drain_frames();
      steady = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_quadrants();
      test_phase_extremes();
      test_channel_limits();
      test_unused_index();
      test_random_tones(7, 60);
      test_backpressure();
      drain_frames();
      $display("covered %0d frames and %0d samples over %0d register writes,",
               frames_sent, samples_checked, config_writes);
      $display("including all quadrants, channel counts 0 to 15 and a long output hold");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
